@@ rtl/avc_pkg.sv @@
// Package for the length-prefixed NAL unit splitter.
// Holds shared constants, status codes and the result descriptor type.
// Used by the parser, the result queue and the top level.
`timescale 1ns / 1ps

package avc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_NAL_UNITS_DEF = 100;
    localparam int OFFSET_BITS_DEF   = 24;

    // Fixed field widths
    localparam int FIELD_W = 24;
    localparam int KEPT_W  = 7;

    // NAL unit types that may be dropped when ref_idc is zero
    localparam logic [4:0] TYPE_FILLER = 5'd12;
    localparam logic [4:0] TYPE_SEI    = 5'd6;
    localparam logic [4:0] TYPE_AUD    = 5'd9;

    // Length saturation limit
    localparam logic [FIELD_W-1:0] LEN_MAX = 24'hFF_FFFF;

    // Header layout: bytes skipped before the first and before later units
    localparam logic [2:0] SKIP_FIRST = 3'd6;
    localparam logic [2:0] SKIP_NEXT  = 3'd1;

    // Length prefix size in bytes
    localparam logic [2:0] LEN_BYTES_HDR  = 3'd2;
    localparam logic [2:0] LEN_BYTES_NORM = 3'd4;

    // Result queue depth (two pushes per cycle at most)
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    // Descriptor status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One input byte with its framing flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       header_mode;
    } t_byte;

    // One result descriptor
    typedef struct packed {
        logic [FIELD_W-1:0] nal_offset;
        logic [FIELD_W-1:0] nal_length;
        logic [4:0]         nal_type;
        logic [1:0]         ref_idc;
        logic               marker;
        t_status            status;
        logic               run_last;
    } t_result;

    // Up to two results written to the queue in one cycle (slot 0 first)
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_res_push;

    // Build a descriptor with run_last clear
    function automatic t_result mk_result(
        input logic [FIELD_W-1:0] off,
        input logic [FIELD_W-1:0] len,
        input logic [4:0]         nal_type,
        input logic [1:0]         ref_idc,
        input logic               marker,
        input t_status            status
    );
        t_result r;
        r.nal_offset = off;
        r.nal_length = len;
        r.nal_type   = nal_type;
        r.ref_idc    = ref_idc;
        r.marker     = marker;
        r.status     = status;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/avc_byte_if.sv @@
// Input byte channel: valid/ready handshake carrying one packet byte.
// Depends on nothing else.
`timescale 1ns / 1ps

interface avc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       header_mode;

    modport source (output valid, data_byte, first_byte, last_byte, header_mode,
                    input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, header_mode,
                    output ready);
endinterface

@@ rtl/avc_nal_if.sv @@
// Result channel: valid/ready handshake carrying one NAL unit descriptor.
// Depends on nothing else.
`timescale 1ns / 1ps

interface avc_nal_if;
    logic        valid;
    logic        ready;
    logic [23:0] nal_offset;
    logic [23:0] nal_length;
    logic [4:0]  nal_type;
    logic [1:0]  ref_idc;
    logic        marker;
    logic [1:0]  status;
    logic        run_last;

    modport source (output valid, nal_offset, nal_length, nal_type, ref_idc, marker,
                    status, run_last, input ready);
    modport sink   (input valid, nal_offset, nal_length, nal_type, ref_idc, marker,
                    status, run_last, output ready);
endinterface

@@ rtl/avc_parser.sv @@
// Byte parser: input register, per-packet parse state and descriptor build.
// Produces up to two descriptors per byte for the result queue. Uses avc_pkg.
`timescale 1ns / 1ps

module avc_parser
    import avc_pkg::*;
#(
    parameter int MAX_NAL_UNITS = MAX_NAL_UNITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_byte     i_item,
    output logic      o_busy,
    output t_res_push o_push
);

    typedef enum logic [2:0] {
        PH_FIRST     = 3'd0,
        PH_NEXT      = 3'd1,
        PH_SKIP      = 3'd2,
        PH_LEN       = 3'd3,
        PH_HDR       = 3'd4,
        PH_BODY_KEPT = 3'd5,
        PH_BODY_DROP = 3'd6
    } t_phase;

    // Input register
    logic  r_in_valid;
    t_byte r_in;

    // Parse state
    t_phase                 r_ph,   n_ph;
    logic [2:0]             r_fc,   n_fc;
    logic [31:0]            r_acc,  n_acc;
    logic [FIELD_W-1:0]     r_left, n_left;
    logic [OFFSET_BITS-1:0] r_pos,  n_pos;
    logic [FIELD_W-1:0]     r_hoff, n_hoff;
    logic [FIELD_W-1:0]     r_hlen, n_hlen;
    logic [4:0]             r_htyp, n_htyp;
    logic [1:0]             r_href, n_href;
    logic                   r_hv,   n_hv;
    logic [KEPT_W-1:0]      r_kc,   n_kc;
    logic                   r_stop, n_stop;

    assign o_busy = r_in_valid;

    // Per-byte parse: boundary handling, phase step, then end-of-packet
    always_comb begin
        t_result            v_res [2];
        logic [1:0]         v_n;
        logic [OFFSET_BITS-1:0] v_cur;
        logic [FIELD_W-1:0] v_sat;
        logic [4:0]         v_typ;
        logic [1:0]         v_ref;
        logic               v_kept;
        logic               v_done;
        logic               v_mk;
        logic               v_hm;

        v_res[0] = '0;
        v_res[1] = '0;
        v_n      = 2'd0;
        v_done   = 1'b0;
        v_hm     = r_in.header_mode;
        v_typ    = r_in.data_byte[4:0];
        v_ref    = r_in.data_byte[6:5];
        v_kept   = 1'b0;
        v_sat    = '0;
        v_mk     = ~v_hm;

        n_ph = r_ph;  n_fc = r_fc;  n_acc = r_acc;  n_left = r_left;  n_pos = r_pos;
        n_hoff = r_hoff;  n_hlen = r_hlen;  n_htyp = r_htyp;  n_href = r_href;
        n_hv = r_hv;  n_kc = r_kc;  n_stop = r_stop;

        // A first byte restarts the packet
        if (r_in.first_byte) begin
            n_ph = PH_FIRST;  n_fc = '0;  n_acc = '0;  n_left = '0;  n_pos = '0;
            n_hoff = '0;  n_hlen = '0;  n_htyp = '0;  n_href = '0;
            n_hv = 1'b0;  n_kc = '0;  n_stop = 1'b0;
        end
        v_cur = n_pos;

        if (r_in_valid && !n_stop) begin
            // Unit boundary: table full check, then choose skip or length
            if (n_ph inside {PH_FIRST, PH_NEXT}) begin
                if (n_kc >= KEPT_W'(MAX_NAL_UNITS)) begin
                    if (n_hv) begin
                        v_res[0] = mk_result(n_hoff, n_hlen, n_htyp, n_href, 1'b0, ST_OK);
                        v_n = 2'd1;
                    end
                    v_res[v_n[0]] = mk_result(FIELD_W'(v_cur), '0, '0, '0, 1'b0, ST_FULL);
                    v_n    = v_n + 2'd1;
                    n_stop = 1'b1;
                    n_hv   = 1'b0;
                    n_pos  = v_cur + OFFSET_BITS'(1);
                    v_done = 1'b1;
                end else if (v_hm) begin
                    n_fc = (n_ph == PH_FIRST) ? SKIP_FIRST : SKIP_NEXT;
                    n_ph = PH_SKIP;
                end else begin
                    n_fc  = '0;
                    n_acc = '0;
                    n_ph  = PH_LEN;
                end
            end

            if (!v_done) begin
                case (n_ph)
                    PH_SKIP: begin
                        if (n_fc != '0) n_fc = n_fc - 3'd1;
                        if (n_fc == '0) begin
                            n_acc = '0;
                            n_ph  = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_acc = {n_acc[23:0], r_in.data_byte};
                        n_fc  = n_fc + 3'd1;
                        if (n_fc >= (v_hm ? LEN_BYTES_HDR : LEN_BYTES_NORM)) begin
                            v_sat = (|n_acc[31:24]) ? LEN_MAX : n_acc[23:0];
                            n_acc = {8'd0, v_sat};
                            n_fc  = '0;
                            if (v_sat == '0) begin
                                n_ph = PH_NEXT;
                            end else begin
                                n_left = v_sat;
                                n_ph   = PH_HDR;
                            end
                        end
                    end
                    PH_HDR: begin
                        v_kept = !(v_typ == TYPE_FILLER || v_typ == TYPE_SEI ||
                                   v_typ == TYPE_AUD) || (v_ref != 2'd0);
                        if (v_kept) begin
                            if (n_hv) begin
                                v_res[0] = mk_result(n_hoff, n_hlen, n_htyp, n_href,
                                                     1'b0, ST_OK);
                                v_n = 2'd1;
                            end
                            n_hoff = FIELD_W'(v_cur);
                            n_hlen = n_acc[23:0];
                            n_htyp = v_typ;
                            n_href = v_ref;
                            n_hv   = 1'b1;
                            n_kc   = n_kc + KEPT_W'(1);
                        end
                        if (n_left != '0) n_left = n_left - FIELD_W'(1);
                        n_ph = (n_left == '0) ? PH_NEXT :
                               (v_kept ? PH_BODY_KEPT : PH_BODY_DROP);
                    end
                    PH_BODY_KEPT, PH_BODY_DROP: begin
                        if (n_left != '0) n_left = n_left - FIELD_W'(1);
                        if (n_left == '0) n_ph = PH_NEXT;
                    end
                    default: n_ph = PH_NEXT;
                endcase

                n_pos = v_cur + OFFSET_BITS'(1);

                // End of packet: flush the held descriptor, flag early ends
                if (r_in.last_byte) begin
                    if (n_ph inside {PH_FIRST, PH_NEXT}) begin
                        if (n_hv) begin
                            v_res[v_n[0]] = mk_result(n_hoff, n_hlen, n_htyp, n_href,
                                                      v_mk, ST_OK);
                            v_n = v_n + 2'd1;
                        end
                    end else if (n_ph == PH_BODY_KEPT && n_hv) begin
                        n_hlen = n_acc[23:0] - n_left;
                        v_res[v_n[0]] = mk_result(n_hoff, n_hlen, n_htyp, n_href,
                                                  v_mk, ST_TRUNC);
                        v_n = v_n + 2'd1;
                    end else begin
                        if (n_hv) begin
                            v_res[v_n[0]] = mk_result(n_hoff, n_hlen, n_htyp, n_href,
                                                      v_mk, ST_OK);
                            v_n = v_n + 2'd1;
                        end
                        v_res[v_n[0]] = mk_result(FIELD_W'(v_cur), '0, '0, '0, 1'b0,
                                                  ST_TRUNC);
                        v_n = v_n + 2'd1;
                    end
                    n_stop = 1'b1;
                    n_hv   = 1'b0;
                end
            end
        end else if (!r_in_valid) begin
            // No byte in the input register: hold the state
            n_ph = r_ph;  n_fc = r_fc;  n_acc = r_acc;  n_left = r_left;  n_pos = r_pos;
            n_hoff = r_hoff;  n_hlen = r_hlen;  n_htyp = r_htyp;  n_href = r_href;
            n_hv = r_hv;  n_kc = r_kc;  n_stop = r_stop;
        end

        // Flag the final result of this byte
        if (v_n == 2'd1) v_res[0].run_last = 1'b1;
        if (v_n == 2'd2) v_res[1].run_last = 1'b1;

        o_push.v0 = (v_n != 2'd0);
        o_push.v1 = (v_n == 2'd2);
        o_push.r0 = v_res[0];
        o_push.r1 = v_res[1];
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_in <= i_item;
        end
    end

    // Parse state and input valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ph   <= PH_FIRST;
            r_fc   <= '0;
            r_acc  <= '0;
            r_left <= '0;
            r_pos  <= '0;
            r_hoff <= '0;
            r_hlen <= '0;
            r_htyp <= '0;
            r_href <= '0;
            r_hv   <= 1'b0;
            r_kc   <= '0;
            r_stop <= 1'b0;
        end else begin
            r_in_valid <= i_take;
            r_ph   <= n_ph;
            r_fc   <= n_fc;
            r_acc  <= n_acc;
            r_left <= n_left;
            r_pos  <= n_pos;
            r_hoff <= n_hoff;
            r_hlen <= n_hlen;
            r_htyp <= n_htyp;
            r_href <= n_href;
            r_hv   <= n_hv;
            r_kc   <= n_kc;
            r_stop <= n_stop;
        end
    end

endmodule

@@ rtl/avc_res_fifo.sv @@
// Result queue: takes up to two descriptors per cycle, hands out one.
// Head entry drives the result channel directly. Uses avc_pkg.
`timescale 1ns / 1ps

module avc_res_fifo
    import avc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_res_push            i_push,
    input  logic                 i_pop,
    output logic                 o_valid,
    output t_result              o_head,
    output logic [RES_CNT_W-1:0] o_fill
);

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wp, r_rp;
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_PTR_W-1:0] w_wp1;
    logic [RES_CNT_W-1:0] w_n_push;

    assign w_wp1    = r_wp + RES_PTR_W'(1);
    assign w_n_push = RES_CNT_W'(i_push.v0) + RES_CNT_W'(i_push.v1);
    assign o_valid  = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];
    assign o_fill   = r_cnt;

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wp]  <= i_push.r0;
        if (i_push.v1) r_mem[w_wp1] <= i_push.r1;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RES_PTR_W'(w_n_push);
            if (i_pop) r_rp <= r_rp + RES_PTR_W'(1);
            r_cnt <= r_cnt + w_n_push - RES_CNT_W'(i_pop);
        end
    end

endmodule

@@ rtl/avc_length_prefixed_nal_splitter.sv @@
// Top level of the length-prefixed NAL unit splitter.
// Instantiates avc_parser and avc_res_fifo; uses avc_pkg and both channel interfaces.
// Usage:
//   i_in carries one packet byte per request with first_byte, last_byte and
//   header_mode. o_out carries NAL descriptors (offset, length, type, ref_idc,
//   marker, status, run_last); a byte gives zero, one or two descriptors and
//   run_last marks the final one that a byte causes.
//   A byte is registered on acceptance and parsed from that register in the next
//   cycle; its descriptors are then written into an eight-entry result queue,
//   whose head entry drives o_out directly.
//   One byte is accepted every cycle while the queue has room for the
//   descriptors of the byte in flight and of the new one; the queue and its
//   single read port set that limit, so a stalled receiver holds i_in.ready
//   low once the queue fills, without losing any descriptor.
//   Reset (synchronous, active low) empties the queue and puts the parser at
//   the start of a packet at offset zero; bytes sent without first_byte after
//   reset are parsed as a new packet.
`timescale 1ns / 1ps

module avc_length_prefixed_nal_splitter
    import avc_pkg::*;
#(
    parameter int MAX_NAL_UNITS = MAX_NAL_UNITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    avc_byte_if.sink     i_in,
    avc_nal_if.source    o_out
);

    logic                 w_take;
    logic                 w_busy;
    logic                 w_pop;
    logic                 w_head_valid;
    t_byte                w_item;
    t_res_push            w_push;
    t_result              w_head;
    logic [RES_CNT_W-1:0] w_fill;

    // Room for two descriptors per byte, counting the byte in flight
    assign i_in.ready = w_busy ? (w_fill <= RES_CNT_W'(RES_DEPTH - 4))
                               : (w_fill <= RES_CNT_W'(RES_DEPTH - 2));
    assign w_take     = i_in.valid & i_in.ready;

    assign w_item.data_byte   = i_in.data_byte;
    assign w_item.first_byte  = i_in.first_byte;
    assign w_item.last_byte   = i_in.last_byte;
    assign w_item.header_mode = i_in.header_mode;

    avc_parser #(
        .MAX_NAL_UNITS (MAX_NAL_UNITS),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (w_item),
        .o_busy  (w_busy),
        .o_push  (w_push)
    );

    avc_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head),
        .o_fill  (w_fill)
    );

    // Result channel
    assign w_pop            = w_head_valid & o_out.ready;
    assign o_out.valid      = w_head_valid;
    assign o_out.nal_offset = w_head.nal_offset;
    assign o_out.nal_length = w_head.nal_length;
    assign o_out.nal_type   = w_head.nal_type;
    assign o_out.ref_idc    = w_head.ref_idc;
    assign o_out.marker     = w_head.marker;
    assign o_out.status     = w_head.status;
    assign o_out.run_last   = w_head.run_last;

`ifndef SYNTHESIS
    // Second descriptor slot is only used after the first
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.v1 |-> w_push.v0)
        else $error("second descriptor pushed without the first");

    // Acceptance gating keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    // Table-full notices never carry a marker or a length
    a_full_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_FULL) |->
            (!o_out.marker && o_out.nal_length == '0))
        else $error("table-full notice with marker or length");
`endif

endmodule

@@ tb/tb_avc_length_prefixed_nal_splitter.sv @@
// Testbench for the length-prefixed NAL unit splitter: sends packet bytes, predicts
// every descriptor the block should give and checks each one in order of arrival.
// Depends on avc_pkg, avc_byte_if, avc_nal_if and avc_length_prefixed_nal_splitter.
`timescale 1ns / 1ps

module tb_avc_length_prefixed_nal_splitter
    import avc_pkg::*;
();

    localparam int MAX_UNITS       = MAX_NAL_UNITS_DEF;
    localparam int BYTES_PER_PHASE = 120;

    // Phases of the splitter's parse, as the predictor tracks them
    typedef enum logic [2:0] {
        P_SEEK_FIRST,
        P_SEEK_NEXT,
        P_SKIP,
        P_PREFIX,
        P_HEADER,
        P_BODY_KEPT,
        P_BODY_DROPPED
    } t_split_phase;

    logic i_clk;
    logic i_rst_n;

    avc_byte_if in_if ();
    avc_nal_if  out_if ();

    avc_length_prefixed_nal_splitter #(
        .MAX_NAL_UNITS (MAX_UNITS),
        .OFFSET_BITS   (OFFSET_BITS_DEF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state
    t_split_phase split_phase;
    logic [2:0]   fld_cnt;
    logic [31:0]  len_acc;
    logic [23:0]  body_left;
    logic [23:0]  byte_pos;
    t_result      held;
    logic         held_ok;
    logic [6:0]   kept_n;
    logic         halted;

    // Descriptors predicted but not yet seen, oldest first
    t_result desc_due[$];
    // Packet under construction
    t_byte   pkt_q[$];

    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int err_n;
    int parsed_n;
    int checked_n;
    int trunc_n;
    int full_n;
    int in_stall_n;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void restart_split();
        split_phase = P_SEEK_FIRST;
        fld_cnt     = '0;
        len_acc     = '0;
        body_left   = '0;
        byte_pos    = '0;
        held        = '0;
        held_ok     = 1'b0;
        kept_n      = '0;
        halted      = 1'b0;
    endfunction

    function automatic t_result held_as(input logic mk, input t_status st);
        t_result r;
        r          = held;
        r.marker   = mk;
        r.status   = st;
        r.run_last = 1'b0;
        return r;
    endfunction

    // Early-end or table-full notice at the current byte
    function automatic t_result notice_at(input logic [23:0] pos, input t_status st);
        t_result r;
        r            = '0;
        r.nal_offset = pos;
        r.status     = st;
        return r;
    endfunction

    // Advance the predicted parse by one accepted byte, queueing its descriptors
    function automatic void split_byte(input t_byte b);
        int          n0;
        logic [23:0] pos;
        logic [4:0]  ty;
        logic [1:0]  rf;
        logic        kept;
        logic [31:0] len;
        logic        mk;
        logic        boundary;

        n0 = desc_due.size();
        if (b.first_byte) begin
            restart_split();
        end else if (halted) begin
            return;
        end
        parsed_n++;
        pos      = byte_pos;
        boundary = (split_phase == P_SEEK_FIRST || split_phase == P_SEEK_NEXT);

        if (boundary && kept_n >= MAX_UNITS) begin
            // table full: flush the held unit without marker, then stop
            if (held_ok) desc_due.push_back(held_as(1'b0, ST_OK));
            desc_due.push_back(notice_at(pos, ST_FULL));
            halted  = 1'b1;
            held_ok = 1'b0;
        end else begin
            // pick the layout of the next unit from this byte's mode
            if (boundary) begin
                if (b.header_mode) begin
                    fld_cnt     = (split_phase == P_SEEK_FIRST) ? SKIP_FIRST : SKIP_NEXT;
                    split_phase = P_SKIP;
                end else begin
                    fld_cnt     = '0;
                    len_acc     = '0;
                    split_phase = P_PREFIX;
                end
            end

            case (split_phase)
                P_SKIP: begin
                    if (fld_cnt != 0) fld_cnt--;
                    if (fld_cnt == 0) begin
                        len_acc     = '0;
                        split_phase = P_PREFIX;
                    end
                end
                P_PREFIX: begin
                    len_acc = {len_acc[23:0], b.data_byte};
                    fld_cnt = fld_cnt + 3'd1;
                    if (fld_cnt >= (b.header_mode ? LEN_BYTES_HDR : LEN_BYTES_NORM)) begin
                        len     = (len_acc > {8'd0, LEN_MAX}) ? {8'd0, LEN_MAX} : len_acc;
                        len_acc = len;
                        fld_cnt = '0;
                        if (len == 0) begin
                            split_phase = P_SEEK_NEXT;
                        end else begin
                            body_left   = len[23:0];
                            split_phase = P_HEADER;
                        end
                    end
                end
                P_HEADER: begin
                    ty   = b.data_byte[4:0];
                    rf   = b.data_byte[6:5];
                    kept = !(ty == TYPE_FILLER || ty == TYPE_SEI || ty == TYPE_AUD)
                           || rf != 2'd0;
                    if (kept) begin
                        if (held_ok) desc_due.push_back(held_as(1'b0, ST_OK));
                        held            = '0;
                        held.nal_offset = pos;
                        held.nal_length = len_acc[23:0];
                        held.nal_type   = ty;
                        held.ref_idc    = rf;
                        held_ok         = 1'b1;
                        kept_n          = kept_n + 7'd1;
                    end
                    if (body_left != 0) body_left--;
                    if (body_left == 0) begin
                        split_phase = P_SEEK_NEXT;
                    end else if (kept) begin
                        split_phase = P_BODY_KEPT;
                    end else begin
                        split_phase = P_BODY_DROPPED;
                    end
                end
                P_BODY_KEPT, P_BODY_DROPPED: begin
                    if (body_left != 0) body_left--;
                    if (body_left == 0) split_phase = P_SEEK_NEXT;
                end
                default: split_phase = P_SEEK_NEXT;
            endcase

            // end of packet
            if (b.last_byte) begin
                mk = ~b.header_mode;
                if (split_phase == P_SEEK_FIRST || split_phase == P_SEEK_NEXT) begin
                    if (held_ok) desc_due.push_back(held_as(mk, ST_OK));
                end else if (split_phase == P_BODY_KEPT && held_ok) begin
                    held.nal_length = len_acc[23:0] - body_left;
                    desc_due.push_back(held_as(mk, ST_TRUNC));
                end else begin
                    if (held_ok) desc_due.push_back(held_as(mk, ST_OK));
                    desc_due.push_back(notice_at(pos, ST_TRUNC));
                end
                halted  = 1'b1;
                held_ok = 1'b0;
            end
        end

        byte_pos = pos + 24'd1;
        if (desc_due.size() > n0) desc_due[desc_due.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_byte mk_byte(input logic [7:0] d, input logic hm);
        t_byte b;
        b             = '0;
        b.data_byte   = d;
        b.header_mode = hm;
        return b;
    endfunction

    // Header byte, biased towards the droppable types
    function automatic logic [7:0] rand_hdr();
        logic [7:0] h;
        h = 8'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0:       h[4:0] = TYPE_SEI;
                1:       h[4:0] = TYPE_AUD;
                default: h[4:0] = TYPE_FILLER;
            endcase
            if ($urandom_range(0, 1) == 1) h[6:5] = 2'b00;
        end
        return h;
    endfunction

    // Header byte of a unit that is always kept
    function automatic logic [7:0] kept_hdr();
        logic [7:0] h;
        h = 8'($urandom);
        if (h[6:5] == 2'b00 && (h[4:0] == TYPE_SEI || h[4:0] == TYPE_AUD
                                || h[4:0] == TYPE_FILLER))
            h[6:5] = 2'($urandom_range(1, 3));
        return h;
    endfunction

    // Append one unit: skip/spacer bytes in header layout, length prefix, header, body
    task automatic add_unit(input logic hm, input logic [31:0] len, input logic [7:0] hdr,
                            input int body_n);
        if (hm) begin
            repeat (pkt_q.size() == 0 ? int'(SKIP_FIRST) : int'(SKIP_NEXT))
                pkt_q.push_back(mk_byte(8'($urandom), hm));
            pkt_q.push_back(mk_byte(len[15:8], hm));
            pkt_q.push_back(mk_byte(len[7:0], hm));
        end else begin
            for (int i = 3; i >= 0; i--) pkt_q.push_back(mk_byte(len[8*i +: 8], hm));
        end
        if ((hm && len[15:0] != 0) || (!hm && len != 0)) begin
            pkt_q.push_back(mk_byte(hdr, hm));
            repeat (body_n) pkt_q.push_back(mk_byte(8'($urandom), hm));
        end
    endtask

    // Offer one byte, with a random gap first, and predict once it is taken
    task automatic push_byte(input t_byte b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= b.data_byte;
        in_if.first_byte  <= b.first_byte;
        in_if.last_byte   <= b.last_byte;
        in_if.header_mode <= b.header_mode;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        split_byte(b);
    endtask

    task automatic send_pkt(input bit mark_first, input bit mark_last);
        if (pkt_q.size() == 0) return;
        pkt_q[0].first_byte = mark_first;
        if (mark_last) pkt_q[pkt_q.size() - 1].last_byte = 1'b1;
        foreach (pkt_q[i]) push_byte(pkt_q[i]);
        pkt_q.delete();
    endtask

    // One random packet: mostly well formed, some cut short, restarted, mode-flipped,
    // followed by junk, or pure noise
    task automatic random_packet();
        logic        hm;
        logic [31:0] len;
        int          units;
        int          body;
        int          damage;
        int          cut;
        bit          open_end;
        t_byte       nb;

        hm       = ($urandom_range(0, 3) == 0);
        units    = $urandom_range(1, 6);
        open_end = 1'b0;
        for (int u = 0; u < units && !open_end; u++) begin
            case ($urandom_range(0, 19))
                0: begin
                    len  = 0;
                    body = 0;
                end
                1: begin
                    // length far beyond what is sent: packet ends inside this unit
                    if (hm) len = $urandom_range(300, 65535);
                    else    len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom;
                    body     = $urandom_range(0, 4);
                    open_end = 1'b1;
                end
                default: begin
                    len  = $urandom_range(1, 12);
                    body = len - 1;
                end
            endcase
            add_unit(hm, len, rand_hdr(), body);
        end

        damage = $urandom_range(0, 99);
        if (damage < 15) begin
            cut = $urandom_range(1, pkt_q.size() - 1);
            while (pkt_q.size() > cut) void'(pkt_q.pop_back());
            send_pkt(1'b1, 1'b1);
        end else if (damage < 23) begin
            // no final byte: the next packet's first byte restarts the parse
            send_pkt(1'b1, 1'b0);
        end else if (damage < 29) begin
            repeat ($urandom_range(1, 3)) begin
                cut = $urandom_range(0, pkt_q.size() - 1);
                pkt_q[cut].header_mode = ~pkt_q[cut].header_mode;
            end
            send_pkt(1'b1, 1'b1);
        end else if (damage < 34) begin
            send_pkt(1'b1, 1'b1);
            repeat ($urandom_range(1, 4)) begin
                nb           = mk_byte(8'($urandom), 1'($urandom_range(0, 1)));
                nb.last_byte = 1'($urandom_range(0, 1));
                push_byte(nb);
            end
        end else if (damage < 38) begin
            pkt_q.delete();
            repeat ($urandom_range(1, 12)) begin
                nb           = mk_byte(8'($urandom), 1'($urandom_range(0, 1)));
                nb.last_byte = ($urandom_range(0, 5) == 0);
                pkt_q.push_back(nb);
            end
            send_pkt(1'b1, 1'($urandom_range(0, 1)));
        end else begin
            send_pkt(1'b1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed: parse straight after reset, drops, zero length, header-mode
    // truncation and a one-byte packet
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // no first byte after reset: parsed as a packet from offset zero, marker set
        add_unit(1'b0, 32'd1, 8'h65, 0);
        send_pkt(1'b0, 1'b1);
        // delimiter with zero ref_idc then a zero-length unit: nothing kept, no result
        add_unit(1'b0, 32'd1, {3'b000, TYPE_AUD}, 0);
        add_unit(1'b0, 32'd0, 8'h00, 0);
        send_pkt(1'b1, 1'b1);
        // header layout, packet ends inside a kept body: truncated, no marker
        add_unit(1'b1, 32'd3, 8'hE7, 1);
        send_pkt(1'b1, 1'b1);
        // first and last on the same byte: ends inside the length prefix
        pkt_q.push_back(mk_byte(8'hFF, 1'b0));
        send_pkt(1'b1, 1'b1);
    endtask

    task automatic run_random_traffic(input int idle_pct, input int stall);
        int stop_at;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        stop_at       = parsed_n + BYTES_PER_PHASE;
        while (parsed_n < stop_at) random_packet();
    endtask

    // More kept units than the table holds, with some dropped ones mixed in
    task automatic test_table_full(input logic hm);
        int kept_units;
        kept_units = 0;
        while (kept_units <= MAX_UNITS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_unit(hm, 32'd1, {1'($urandom_range(0, 1)), 2'b00, TYPE_FILLER}, 0);
            end else begin
                add_unit(hm, 32'd1, kept_hdr(), 0);
                kept_units++;
            end
        end
        repeat (4) pkt_q.push_back(mk_byte(8'($urandom), hm));
        send_pkt(1'b1, 1'b1);
    endtask

    // Receiver holds off for a long stretch while the sender keeps requesting
    task automatic test_stalled_receiver();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left    <= 400;
        for (int u = 0; u < 60; u++) add_unit(1'b0, 32'd1, kept_hdr(), 0);
        send_pkt(1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Receiver ready: long hold-off when asked, else random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void cmp_field(input string fname, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            err_n++;
        end
    endfunction

    // Compare every accepted descriptor with the oldest one predicted
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && in_if.valid && !in_if.ready) in_stall_n++;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (desc_due.size() == 0) begin
                $error("descriptor at offset %0d with none predicted", out_if.nal_offset);
                err_n++;
            end else begin
                want = desc_due.pop_front();
                cmp_field("nal_offset", want.nal_offset, out_if.nal_offset);
                cmp_field("nal_length", want.nal_length, out_if.nal_length);
                cmp_field("nal_type", want.nal_type, out_if.nal_type);
                cmp_field("ref_idc", want.ref_idc, out_if.ref_idc);
                cmp_field("marker", want.marker, out_if.marker);
                cmp_field("status", want.status, out_if.status);
                cmp_field("run_last", want.run_last, out_if.run_last);
                checked_n++;
                if (want.status == ST_TRUNC) trunc_n++;
                if (want.status == ST_FULL) full_n++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.data_byte   = '0;
        in_if.first_byte  = 1'b0;
        in_if.last_byte   = 1'b0;
        in_if.header_mode = 1'b0;
        out_if.ready      = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_left         = 0;
        err_n             = 0;
        parsed_n          = 0;
        checked_n         = 0;
        trunc_n           = 0;
        full_n            = 0;
        in_stall_n        = 0;
        restart_split();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        run_random_traffic(0, 0);
        test_table_full(1'b0);
        test_table_full(1'b1);
        test_stalled_receiver();
        run_random_traffic(83, 0);
        run_random_traffic(0, 83);
        run_random_traffic(38, 38);

        // drain
        in_if.valid  <= 1'b0;
        stall_pct     = 0;
        while (desc_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d parsed bytes in both layouts and %0d descriptors",
                 parsed_n, checked_n);
        $display("  %0d early-end, %0d table-full results; input held for %0d cycles",
                 trunc_n, full_n, in_stall_n);
        if (err_n == 0) begin
            $display("tb_avc_length_prefixed_nal_splitter: clean");
        end else begin
            $display("tb_avc_length_prefixed_nal_splitter: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timed out with %0d descriptors outstanding", desc_due.size());
        $display("tb_avc_length_prefixed_nal_splitter: errors");
        $finish;
    end

endmodule
